FILE: rtl/csm_pkg.sv
package csm_pkg;

  localparam int unsigned TICK_BITS = 55;
  localparam int unsigned TDATA_IN_BITS = 56;
  localparam int unsigned TDATA_OUT_BITS = 8;
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 17;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MINUTE_WINDOW = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HOUR_WINDOW = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DAY_WINDOW = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MONTH_WINDOW = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WEEKDAY_WINDOW = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_GAP = 3'd5;

  localparam logic [11:0] MINUTE_WINDOW_RESET = 12'd3776;
  localparam logic [9:0] HOUR_WINDOW_RESET = 10'd736;
  localparam logic [9:0] DAY_WINDOW_RESET = 10'd992;
  localparam logic [7:0] MONTH_WINDOW_RESET = 8'd192;
  localparam logic [5:0] WEEKDAY_WINDOW_RESET = 6'd56;
  localparam logic [16:0] MIN_GAP_RESET = 17'd59;

  // Declared from the top bit down, so now_seconds lands in the lowest bits.
  typedef struct packed {
    logic [2:0] weekday;
    logic [3:0] month;
    logic [4:0] day_of_month;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [31:0] now_seconds;
  } tick_t;

  typedef struct packed {
    logic [11:0] minute_window;
    logic [9:0] hour_window;
    logic [9:0] day_window;
    logic [7:0] month_window;
    logic [5:0] weekday_window;
    logic [16:0] min_gap;
  } cfg_t;

  typedef struct packed {
    logic fire;
    logic catch_up;
  } upd_t;

  function automatic logic in_window(input logic [5:0] v, input logic [5:0] lo,
                                     input logic [5:0] hi);
    in_window = (v >= lo) && (v <= hi);
  endfunction

endpackage

FILE: rtl/cron_schedule_matcher.sv
// Input register, then evaluation, then output register. One request per cycle
// while the output is not stalled; the evaluation stage reads and updates the
// last-run state in the same cycle, so consecutive ticks see each other's effects.
// Reset clears the stage valids, the last-run state and has-run flag, and loads
// the window registers with full windows and a 59 second minimum gap.
module cron_schedule_matcher import csm_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // now_seconds[31:0], minute[37:32], hour[42:38], day_of_month[47:43],
  // month[51:48], weekday[54:52], zero fill [55]
  input  logic [TDATA_IN_BITS-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // fire[0], zero fill [7:1]
  output logic [TDATA_OUT_BITS-1:0] m_axis_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_t                 cfg;
  tick_t                in_tick;
  logic                 in_valid;
  logic                 fire_q;
  logic [TIME_BITS-1:0] last_run_time;
  logic                 last_run_valid;
  logic                 has_run;
  logic                 process;
  upd_t                 upd;
  logic [TIME_BITS-1:0] catch_up_time;

  assign process = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || process;
  assign cfg_ready = 1'b1;
  assign m_axis_tdata = {{(TDATA_OUT_BITS-1){1'b0}}, fire_q};

  csm_eval #(
    .TIME_BITS(TIME_BITS)
  ) u_eval (
    .tick          (in_tick),
    .cfg           (cfg),
    .last_run_time (last_run_time),
    .last_run_valid(last_run_valid),
    .has_run       (has_run),
    .upd           (upd),
    .catch_up_time (catch_up_time)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.minute_window <= MINUTE_WINDOW_RESET;
      cfg.hour_window <= HOUR_WINDOW_RESET;
      cfg.day_window <= DAY_WINDOW_RESET;
      cfg.month_window <= MONTH_WINDOW_RESET;
      cfg.weekday_window <= WEEKDAY_WINDOW_RESET;
      cfg.min_gap <= MIN_GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MINUTE_WINDOW: cfg.minute_window <= cfg_data[11:0];
        REG_HOUR_WINDOW: cfg.hour_window <= cfg_data[9:0];
        REG_DAY_WINDOW: cfg.day_window <= cfg_data[9:0];
        REG_MONTH_WINDOW: cfg.month_window <= cfg_data[7:0];
        REG_WEEKDAY_WINDOW: cfg.weekday_window <= cfg_data[5:0];
        REG_MIN_GAP: cfg.min_gap <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (process) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_tick <= tick_t'(s_axis_tdata[TICK_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (process) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      fire_q <= upd.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_run_valid <= 1'b0;
      has_run <= 1'b0;
    end else if (process) begin
      if (upd.fire || upd.catch_up) begin
        last_run_valid <= 1'b1;
      end
      if (upd.fire) begin
        has_run <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_run_time <= '0;
    end else if (process) begin
      if (upd.fire) begin
        last_run_time <= TIME_BITS'(in_tick.now_seconds);
      end else if (upd.catch_up) begin
        last_run_time <= catch_up_time;
      end
    end
  end

`ifndef SYNTHESIS
  a_has_run_implies_valid: assert property (@(posedge clk) disable iff (rst)
    has_run |-> last_run_valid)
    else $error("has_run set without a recorded run");

  a_fire_records_run: assert property (@(posedge clk) disable iff (rst)
    (process && upd.fire) |=> (has_run && last_run_valid && m_axis_tvalid && fire_q))
    else $error("firing did not record the run");

  a_catch_up_no_fire: assert property (@(posedge clk) disable iff (rst)
    (process && upd.catch_up) |=> (m_axis_tvalid && !fire_q && last_run_valid))
    else $error("catch-up tick fired or left no record");

  a_has_run_sticky: assert property (@(posedge clk) disable iff (rst)
    has_run |=> has_run)
    else $error("has_run cleared outside reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a full pipeline");
`endif

endmodule

FILE: rtl/csm_eval.sv
module csm_eval import csm_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  tick_t                tick,
  input  cfg_t                 cfg,
  input  logic [TIME_BITS-1:0] last_run_time,
  input  logic                 last_run_valid,
  input  logic                 has_run,
  output upd_t                 upd,
  output logic [TIME_BITS-1:0] catch_up_time
);

  logic [31:0] diff;
  logic        gap_ok;
  logic [5:0]  mlo;
  logic [5:0]  mhi;
  logic        single_past;
  logic        need_gap;
  logic        min_ok;
  logic        hour_ok;
  logic        day_ok;
  logic        month_ok;
  logic        weekday_ok;
  logic [5:0]  minutes_late;
  logic [11:0] offset;

  // Wrapped difference read as signed; a negative gap never counts as exceeded.
  assign diff = tick.now_seconds - last_run_time[31:0];
  assign gap_ok = !diff[31] && (diff[30:0] > {14'd0, cfg.min_gap});

  assign mlo = cfg.minute_window[5:0];
  assign mhi = cfg.minute_window[11:6];
  assign single_past = (mlo == mhi) && (tick.minute > mhi);
  assign need_gap = !has_run || gap_ok;

  assign hour_ok = in_window({1'b0, tick.hour}, {1'b0, cfg.hour_window[4:0]},
                             {1'b0, cfg.hour_window[9:5]});
  assign day_ok = in_window({1'b0, tick.day_of_month}, {1'b0, cfg.day_window[4:0]},
                            {1'b0, cfg.day_window[9:5]});
  assign month_ok = in_window({2'b0, tick.month}, {2'b0, cfg.month_window[3:0]},
                              {2'b0, cfg.month_window[7:4]});
  assign weekday_ok = in_window({3'b0, tick.weekday}, {3'b0, cfg.weekday_window[2:0]},
                                {3'b0, cfg.weekday_window[5:3]});

  always_comb begin
    if (single_past) begin
      min_ok = last_run_valid && gap_ok;
    end else begin
      min_ok = in_window(tick.minute, mlo, mhi) && need_gap;
    end
  end

  assign upd.fire = min_ok && hour_ok && day_ok && month_ok && weekday_ok && need_gap;
  assign upd.catch_up = single_past && !last_run_valid;

  // Sixty seconds per missed minute, as 64x - 4x.
  assign minutes_late = tick.minute - mhi;
  assign offset = {minutes_late, 6'd0} - {4'd0, minutes_late, 2'd0};
  assign catch_up_time = TIME_BITS'(tick.now_seconds) - TIME_BITS'(offset);

endmodule
